// ----- rtl/cbv_pkg.sv -----
// Shared types and constants for the command buffer validator.
`default_nettype none

package cbv_pkg;

    localparam int HEADER_LENGTH = 24;
    localparam int RECORD_LENGTH = 32;

    localparam int HDR_BITS = 8 * HEADER_LENGTH;
    localparam int REC_BITS = 8 * RECORD_LENGTH;

    // Status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNCATED = 4'd1;
    localparam logic [3:0] ST_BUDGET    = 4'd2;
    localparam logic [3:0] ST_MAGIC     = 4'd3;
    localparam logic [3:0] ST_SCHEMA    = 4'd4;
    localparam logic [3:0] ST_RESERVED  = 4'd5;
    localparam logic [3:0] ST_COUNT     = 4'd6;
    localparam logic [3:0] ST_BYTECOUNT = 4'd7;
    localparam logic [3:0] ST_EPOCH     = 4'd8;
    localparam logic [3:0] ST_RECSIZE   = 4'd9;
    localparam logic [3:0] ST_OPCODE    = 4'd10;
    localparam logic [3:0] ST_BINDING   = 4'd11;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAX_BYTES      = 3'd0;
    localparam logic [2:0] CFG_MAX_COMMANDS   = 3'd1;
    localparam logic [2:0] CFG_EXPECTED_EPOCH = 3'd2;
    localparam logic [2:0] CFG_MAGIC_WORD     = 3'd3;
    localparam logic [2:0] CFG_SCHEMA_VERSION = 3'd4;
    localparam logic [2:0] CFG_SET_OPCODE     = 3'd5;

    localparam logic RESULT_COMMAND = 1'b0;
    localparam logic RESULT_STATUS  = 1'b1;

    typedef struct packed {
        logic               result_kind;
        logic [3:0]         status_code;
        logic               error_in_record;
        logic [15:0]        record_index;
        logic [31:0]        binding_ordinal;
        logic signed [31:0] self_slot;
        logic signed [31:0] self_generation;
        logic signed [31:0] argument_zero;
        logic               last_result;
    } result_t;

    // Up to two results posted per request; second only used with the first
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t data0;
        result_t data1;
    } push_t;

endpackage

`default_nettype wire

// ----- rtl/cbv_result_queue.sv -----
// Result queue taking up to two results per cycle and handing out one.
`default_nettype none

module cbv_result_queue
    import cbv_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         space_ok,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [PTR_W-1:0] wr_ptr_plus2;
    logic [CNT_W-1:0] push_count;
    logic             pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
        wrap_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign out_valid    = (count_reg != '0);
    assign pop          = out_valid && out_ready;
    assign head         = entries_reg[rd_ptr_reg];
    assign space_ok     = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = wrap_inc(wr_ptr_reg);
    assign wr_ptr_plus2 = wrap_inc(wr_ptr_plus1);
    assign push_count   = CNT_W'(push.valid0) + CNT_W'(push.valid1);

    always_comb
    begin
        priority if (push.valid0 && push.valid1)
        begin
            wr_ptr_next = wr_ptr_plus2;
        end
        else if (push.valid0)
        begin
            wr_ptr_next = wr_ptr_plus1;
        end
        else
        begin
            wr_ptr_next = wr_ptr_reg;
        end
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + push_count - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            entries_reg[wr_ptr_reg] <= push.data0;
        end
        if (push.valid0 && push.valid1)
        begin
            entries_reg[wr_ptr_plus1] <= push.data1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/command_buffer_validator.sv -----
// Command buffer validator: header and record checks on a byte stream.
// A request's results are written into the result queue when it is taken.
// Throughput: one byte per cycle; a request posts up to two results into a
// QUEUE_DEPTH-entry result queue, and requests stall while it has fewer
// than two free entries. Reset clears all buffer control state and loads
// the register defaults; the header and record byte stores are not cleared.
`default_nettype none

module command_buffer_validator
    import cbv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [3:0]       status_code,
    output logic             error_in_record,
    output logic [15:0]      record_index,
    output logic [31:0]      binding_ordinal,
    output logic signed [31:0] self_slot,
    output logic signed [31:0] self_generation,
    output logic signed [31:0] argument_zero,
    output logic             last_result
);

    // Configuration registers
    logic [31:0] max_bytes_reg;
    logic [15:0] max_commands_reg;
    logic [63:0] expected_epoch_reg;
    logic [31:0] magic_word_reg;
    logic [15:0] schema_version_reg;
    logic [15:0] set_opcode_reg;

    // Buffer state
    logic [31:0] byte_position_reg, byte_position_next;
    logic [15:0] record_counter_reg, record_counter_next;
    logic [3:0]  first_error_reg, first_error_next;
    logic [15:0] error_index_reg, error_index_next;
    logic        error_seen_reg, error_seen_next;
    logic [7:0]  header_store_reg [HEADER_LENGTH];
    logic [7:0]  record_store_reg [RECORD_LENGTH];

    logic          accept;
    logic [31:0]   pos;
    logic [31:0]   len;
    logic          in_header;
    logic          rec_active;
    logic [4:0]    rec_offset;
    logic          rec_done;
    logic [HDR_BITS-1:0] hdr;
    logic [REC_BITS-1:0] rec;

    logic [15:0] hdr_count;
    logic [31:0] hdr_expect;
    logic        f_magic, f_schema, f_hres, f_count, f_decl, f_len, f_epoch;
    logic        hdr_ok_nolen;
    logic [3:0]  rec_code;
    logic        tentative;
    logic [3:0]  final_code;
    logic        final_in_rec;
    result_t     cmd_result;
    result_t     fin_result;
    push_t       push;
    result_t     head;
    logic        space_ok;

    assign accept     = in_valid && in_ready;
    assign in_ready   = space_ok;
    assign pos        = byte_position_reg;
    assign len        = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
    assign in_header  = (pos < 32'(HEADER_LENGTH));
    assign rec_offset = pos[4:0] + 5'(RECORD_LENGTH - HEADER_LENGTH % RECORD_LENGTH);

    // Header view with the incoming byte merged at its place; record view with it as the last byte
    always_comb
    begin
        for (int i = 0; i < HEADER_LENGTH; i++)
        begin
            hdr[8*i +: 8] = (pos == 32'(i)) ? data_byte : header_store_reg[i];
        end
        for (int i = 0; i < RECORD_LENGTH - 1; i++)
        begin
            rec[8*i +: 8] = record_store_reg[i];
        end
        rec[REC_BITS-1 -: 8] = data_byte;
    end

    assign hdr_count  = hdr[63:48];
    assign hdr_expect = 32'(HEADER_LENGTH) + {11'd0, hdr_count, 5'd0};
    assign rec_active = !in_header && (record_counter_reg < hdr_count);
    assign rec_done   = rec_active && (rec_offset == 5'(RECORD_LENGTH - 1));

    // Header checks
    assign f_magic  = (hdr[31:0] != magic_word_reg);
    assign f_schema = (hdr[47:32] != schema_version_reg);
    assign f_hres   = (hdr[127:96] != 32'd0);
    assign f_count  = (hdr_count == 16'd0) || (hdr_count > max_commands_reg);
    assign f_decl   = (hdr[95:64] != hdr_expect);
    assign f_len    = (len != hdr_expect);
    assign f_epoch  = (expected_epoch_reg == 64'd0) || (hdr[191:128] != expected_epoch_reg);
    assign hdr_ok_nolen = !(f_magic || f_schema || f_hres || f_count || f_decl || f_epoch);

    // Record checks
    always_comb
    begin
        priority if ((rec[31:16] != 16'd0) || (rec[255:224] != 32'd0))
        begin
            rec_code = ST_RESERVED;
        end
        else if (rec[63:32] != 32'(RECORD_LENGTH))
        begin
            rec_code = ST_RECSIZE;
        end
        else if (rec[15:0] != set_opcode_reg)
        begin
            rec_code = ST_OPCODE;
        end
        else if (rec[95:64] == 32'hFFFF_FFFF)
        begin
            rec_code = ST_BINDING;
        end
        else if (rec[223:192] != 32'd0)
        begin
            rec_code = ST_RESERVED;
        end
        else
        begin
            rec_code = ST_OK;
        end
    end

    assign tentative = rec_done && (rec_code == ST_OK) && !error_seen_reg &&
                       (len <= max_bytes_reg) && hdr_ok_nolen;

    always_comb
    begin
        error_seen_next  = error_seen_reg;
        first_error_next = first_error_reg;
        error_index_next = error_index_reg;
        if (rec_done && (rec_code != ST_OK) && !error_seen_reg)
        begin
            error_seen_next  = 1'b1;
            first_error_next = rec_code;
            error_index_next = record_counter_reg;
        end
    end

    always_comb
    begin
        final_in_rec = 1'b0;
        priority if (len < 32'(HEADER_LENGTH))
        begin
            final_code = ST_TRUNCATED;
        end
        else if (len > max_bytes_reg)
        begin
            final_code = ST_BUDGET;
        end
        else if (f_magic)
        begin
            final_code = ST_MAGIC;
        end
        else if (f_schema)
        begin
            final_code = ST_SCHEMA;
        end
        else if (f_hres)
        begin
            final_code = ST_RESERVED;
        end
        else if (f_count)
        begin
            final_code = ST_COUNT;
        end
        else if (f_decl || f_len)
        begin
            final_code = ST_BYTECOUNT;
        end
        else if (f_epoch)
        begin
            final_code = ST_EPOCH;
        end
        else if (error_seen_next)
        begin
            final_code   = first_error_next;
            final_in_rec = 1'b1;
        end
        else
        begin
            final_code = ST_OK;
        end
    end

    always_comb
    begin
        cmd_result                 = '0;
        cmd_result.result_kind     = RESULT_COMMAND;
        cmd_result.status_code     = ST_OK;
        cmd_result.record_index    = record_counter_reg;
        cmd_result.binding_ordinal = rec[95:64];
        cmd_result.self_slot       = rec[127:96];
        cmd_result.self_generation = rec[159:128];
        cmd_result.argument_zero   = rec[191:160];

        fin_result                 = '0;
        fin_result.result_kind     = RESULT_STATUS;
        fin_result.status_code     = final_code;
        fin_result.error_in_record = final_in_rec;
        fin_result.record_index    = final_in_rec ? error_index_next : 16'd0;
        fin_result.last_result     = 1'b1;

        push = '0;
        if (accept)
        begin
            priority if (tentative)
            begin
                push.valid0 = 1'b1;
                push.data0  = cmd_result;
                push.valid1 = final_byte;
                push.data1  = fin_result;
            end
            else if (final_byte)
            begin
                push.valid0 = 1'b1;
                push.data0  = fin_result;
            end
            else
            begin
                push.valid0 = 1'b0;
            end
        end
    end

    always_comb
    begin
        record_counter_next = record_counter_reg;
        if (rec_done && (record_counter_reg != 16'hFFFF))
        begin
            record_counter_next = record_counter_reg + 16'd1;
        end
        byte_position_next = final_byte ? 32'd0 : len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= '0;
            record_counter_reg <= '0;
            first_error_reg    <= ST_OK;
            error_index_reg    <= '0;
            error_seen_reg     <= 1'b0;
        end
        else if (accept)
        begin
            byte_position_reg <= byte_position_next;
            if (final_byte)
            begin
                record_counter_reg <= '0;
                first_error_reg    <= ST_OK;
                error_index_reg    <= '0;
                error_seen_reg     <= 1'b0;
            end
            else
            begin
                record_counter_reg <= record_counter_next;
                first_error_reg    <= first_error_next;
                error_index_reg    <= error_index_next;
                error_seen_reg     <= error_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_header)
        begin
            header_store_reg[pos[4:0]] <= data_byte;
        end
        if (accept && rec_active)
        begin
            record_store_reg[rec_offset] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg      <= 32'hFFFF_FFFF;
            max_commands_reg   <= 16'hFFFF;
            expected_epoch_reg <= 64'd0;
            magic_word_reg     <= 32'd1111709249;
            schema_version_reg <= 16'd1;
            set_opcode_reg     <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_BYTES:      max_bytes_reg      <= cfg_data[31:0];
                CFG_MAX_COMMANDS:   max_commands_reg   <= cfg_data[15:0];
                CFG_EXPECTED_EPOCH: expected_epoch_reg <= cfg_data;
                CFG_MAGIC_WORD:     magic_word_reg     <= cfg_data[31:0];
                CFG_SCHEMA_VERSION: schema_version_reg <= cfg_data[15:0];
                CFG_SET_OPCODE:     set_opcode_reg     <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    cbv_result_queue #(
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_kind     = head.result_kind;
    assign status_code     = head.status_code;
    assign error_in_record = head.error_in_record;
    assign record_index    = head.record_index;
    assign binding_ordinal = head.binding_ordinal;
    assign self_slot       = head.self_slot;
    assign self_generation = head.self_generation;
    assign argument_zero   = head.argument_zero;
    assign last_result     = head.last_result;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the command buffer validator byte stream.
`default_nettype none

module tb_top;
    import cbv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_BYTES = 60;

    typedef enum int {
        MUT_NONE,
        MUT_TRUNCATE,
        MUT_EXTRA,
        MUT_MAGIC,
        MUT_SCHEMA,
        MUT_HDR_RSVD,
        MUT_COUNT_ZERO,
        MUT_COUNT_HIGH,
        MUT_DECLARED,
        MUT_EPOCH,
        MUT_FLAGS,
        MUT_RECSIZE,
        MUT_OPCODE,
        MUT_BINDING,
        MUT_ARG_ONE,
        MUT_REC_RSVD,
        MUT_FLIP,
        MUT_NOISE
    } mutation_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         data_byte = '0;
    logic               final_byte = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               result_kind;
    logic [3:0]         status_code;
    logic               error_in_record;
    logic [15:0]        record_index;
    logic [31:0]        binding_ordinal;
    logic signed [31:0] self_slot;
    logic signed [31:0] self_generation;
    logic signed [31:0] argument_zero;
    logic               last_result;

    // Predictor copy of the registers
    logic [31:0]        max_bytes_cfg;
    logic [15:0]        max_commands_cfg;
    logic [63:0]        epoch_cfg;
    logic [31:0]        magic_cfg;
    logic [15:0]        schema_cfg;
    logic [15:0]        opcode_cfg;

    // Predictor copy of the per-buffer state
    logic [31:0]        stream_pos;
    logic [HDR_BITS-1:0] hdr_bits;
    logic [REC_BITS-1:0] rec_bits;
    logic [15:0]        rec_count;
    logic [3:0]         first_rec_code;
    logic [15:0]        first_rec_index;
    logic               rec_error_seen;

    result_t            expected_results[$];
    logic [7:0]         frame[$];

    int                 fail_count = 0;
    int                 bytes_sent = 0;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_request = 0;
    int                 hold_left = 0;

    command_buffer_validator DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .final_byte      (final_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .status_code     (status_code),
        .error_in_record (error_in_record),
        .record_index    (record_index),
        .binding_ordinal (binding_ordinal),
        .self_slot       (self_slot),
        .self_generation (self_generation),
        .argument_zero   (argument_zero),
        .last_result     (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_stream();
        stream_pos      = '0;
        hdr_bits        = '0;
        rec_bits        = '0;
        rec_count       = '0;
        first_rec_code  = ST_OK;
        first_rec_index = '0;
        rec_error_seen  = 1'b0;
    endfunction

    function automatic logic [3:0] header_check(input logic check_len,
                                                input logic [31:0] len);
        logic [15:0] count;
        logic [63:0] want_len;
        count    = hdr_bits[48 +: 16];
        want_len = 64'(HEADER_LENGTH) + 64'(count) * 64'(RECORD_LENGTH);
        if (hdr_bits[0 +: 32] != magic_cfg)
            return ST_MAGIC;
        if (hdr_bits[32 +: 16] != schema_cfg)
            return ST_SCHEMA;
        if (hdr_bits[96 +: 32] != 32'd0)
            return ST_RESERVED;
        if (count == 16'd0 || count > max_commands_cfg)
            return ST_COUNT;
        if (want_len > 64'hFFFF_FFFF || 64'(hdr_bits[64 +: 32]) != want_len ||
            (check_len && 64'(len) != want_len))
            return ST_BYTECOUNT;
        if (epoch_cfg == 64'd0 || hdr_bits[128 +: 64] != epoch_cfg)
            return ST_EPOCH;
        return ST_OK;
    endfunction

    function automatic logic [3:0] record_check();
        if (rec_bits[16 +: 16] != 16'd0 || rec_bits[224 +: 32] != 32'd0)
            return ST_RESERVED;
        if (rec_bits[32 +: 32] != 32'(RECORD_LENGTH))
            return ST_RECSIZE;
        if (rec_bits[0 +: 16] != opcode_cfg)
            return ST_OPCODE;
        if (rec_bits[64 +: 32] == 32'hFFFF_FFFF)
            return ST_BINDING;
        if (rec_bits[192 +: 32] != 32'd0)
            return ST_RESERVED;
        return ST_OK;
    endfunction

    // Expected results caused by one accepted request
    function automatic void predict_byte(input logic [7:0] value, input logic last);
        logic [31:0] len;
        logic [3:0]  code;
        int          off;
        result_t     r;
        len = (stream_pos == 32'hFFFF_FFFF) ? stream_pos : stream_pos + 32'd1;
        if (stream_pos < 32'(HEADER_LENGTH))
        begin
            hdr_bits[8 * stream_pos +: 8] = value;
        end
        else if (rec_count < hdr_bits[48 +: 16])
        begin
            off = int'((stream_pos - 32'(HEADER_LENGTH)) % 32'(RECORD_LENGTH));
            rec_bits[8 * off +: 8] = value;
            if (off == RECORD_LENGTH - 1)
            begin
                code = record_check();
                if (code != ST_OK)
                begin
                    if (!rec_error_seen)
                    begin
                        rec_error_seen  = 1'b1;
                        first_rec_code  = code;
                        first_rec_index = rec_count;
                    end
                end
                else if (!rec_error_seen && len <= max_bytes_cfg &&
                         header_check(1'b0, len) == ST_OK)
                begin
                    r = '0;
                    r.result_kind     = RESULT_COMMAND;
                    r.record_index    = rec_count;
                    r.binding_ordinal = rec_bits[64 +: 32];
                    r.self_slot       = rec_bits[96 +: 32];
                    r.self_generation = rec_bits[128 +: 32];
                    r.argument_zero   = rec_bits[160 +: 32];
                    expected_results.push_back(r);
                end
                if (rec_count != 16'hFFFF)
                    rec_count = rec_count + 16'd1;
            end
        end
        stream_pos = len;

        if (last)
        begin
            r = '0;
            r.result_kind = RESULT_STATUS;
            r.last_result = 1'b1;
            if (len < 32'(HEADER_LENGTH))
                r.status_code = ST_TRUNCATED;
            else if (len > max_bytes_cfg)
                r.status_code = ST_BUDGET;
            else
            begin
                r.status_code = header_check(1'b1, len);
                if (r.status_code == ST_OK && rec_error_seen)
                begin
                    r.status_code     = first_rec_code;
                    r.error_in_record = 1'b1;
                    r.record_index    = first_rec_index;
                end
            end
            expected_results.push_back(r);
            clear_stream();
        end
    endfunction

    function automatic string show(input result_t r);
        return $sformatf({"kind=%0d status=%0d in_rec=%0d index=%0d ",
                          "bind=%h slot=%h gen=%h arg0=%h last=%0d"},
                         r.result_kind, r.status_code, r.error_in_record,
                         r.record_index, r.binding_ordinal, r.self_slot,
                         r.self_generation, r.argument_zero, r.last_result);
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {result_kind, status_code, error_in_record, record_index,
                   binding_ordinal, self_slot, self_generation, argument_zero,
                   last_result};
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: %s", show(got));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch:\n  expected %s\n  actual   %s",
                                 show(want), show(got));
                end
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        final_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(value, last);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (index)
            CFG_MAX_BYTES:      max_bytes_cfg    = value[31:0];
            CFG_MAX_COMMANDS:   max_commands_cfg = value[15:0];
            CFG_EXPECTED_EPOCH: epoch_cfg        = value;
            CFG_MAGIC_WORD:     magic_cfg        = value[31:0];
            CFG_SCHEMA_VERSION: schema_cfg       = value[15:0];
            CFG_SET_OPCODE:     opcode_cfg       = value[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic void put_le(input int off, input int nbytes, input logic [63:0] value);
        for (int i = 0; i < nbytes; i++)
            if (off + i < frame.size())
                frame[off + i] = value[8 * i +: 8];
    endfunction

    function automatic void flip_bit(input int off, input int nbytes);
        int pos;
        pos = off + $urandom_range(nbytes - 1);
        if (pos < frame.size())
            frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7));
    endfunction

    function automatic void trim_frame(input int keep);
        while (frame.size() > keep)
            void'(frame.pop_back());
    endfunction

    // Well-formed buffer under the current register settings
    function automatic void build_frame(input int n_rec);
        int          base;
        logic [31:0] bind_word;
        frame.delete();
        repeat (HEADER_LENGTH + RECORD_LENGTH * n_rec) frame.push_back(8'h00);
        put_le(0, 4, 64'(magic_cfg));
        put_le(4, 2, 64'(schema_cfg));
        put_le(6, 2, 64'(n_rec));
        put_le(8, 4, 64'(HEADER_LENGTH + RECORD_LENGTH * n_rec));
        put_le(16, 8, (epoch_cfg != 64'd0) ? epoch_cfg : {$urandom(), $urandom()});
        for (int i = 0; i < n_rec; i++)
        begin
            base      = HEADER_LENGTH + RECORD_LENGTH * i;
            bind_word = pick_word();
            if (bind_word == 32'hFFFF_FFFF)
                bind_word = 32'hFFFF_FFFE;
            put_le(base, 2, 64'(opcode_cfg));
            put_le(base + 4, 4, 64'(RECORD_LENGTH));
            put_le(base + 8, 4, 64'(bind_word));
            put_le(base + 12, 4, 64'(pick_word()));
            put_le(base + 16, 4, 64'(pick_word()));
            put_le(base + 20, 4, 64'(pick_word()));
        end
    endfunction

    function automatic void apply_mutation(input mutation_t kind, input int n_rec);
        int base;
        int count;
        base = HEADER_LENGTH + RECORD_LENGTH * $urandom_range(n_rec - 1);
        case (kind)
            MUT_NONE: ;
            MUT_TRUNCATE:
                if (frame.size() > 1)
                    trim_frame($urandom_range(frame.size() - 1, 1));
            MUT_EXTRA:
                repeat ($urandom_range(40, 1)) frame.push_back(8'($urandom()));
            MUT_MAGIC:      flip_bit(0, 4);
            MUT_SCHEMA:     flip_bit(4, 2);
            MUT_HDR_RSVD:   flip_bit(12, 4);
            MUT_COUNT_ZERO: put_le(6, 2, 64'd0);
            MUT_COUNT_HIGH:
                if (max_commands_cfg != 16'hFFFF)
                begin
                    count = int'(max_commands_cfg) + $urandom_range(3, 1);
                    if (count > 65535)
                        count = 65535;
                    put_le(6, 2, 64'(count));
                    put_le(8, 4, 64'(HEADER_LENGTH + RECORD_LENGTH * count));
                end
            MUT_DECLARED:   flip_bit(8, 4);
            MUT_EPOCH:      flip_bit(16, 8);
            MUT_FLAGS:      flip_bit(base + 2, 2);
            MUT_RECSIZE:    flip_bit(base + 4, 4);
            MUT_OPCODE:     flip_bit(base, 2);
            MUT_BINDING:    put_le(base + 8, 4, 64'hFFFF_FFFF);
            MUT_ARG_ONE:    flip_bit(base + 24, 4);
            MUT_REC_RSVD:   flip_bit(base + 28, 4);
            MUT_FLIP:       flip_bit(0, frame.size());
            MUT_NOISE:
            begin
                frame.delete();
                repeat ($urandom_range(80, 1)) frame.push_back(8'($urandom()));
            end
            default: ;
        endcase
    endfunction

    function automatic mutation_t pick_mutation();
        if ($urandom_range(99) < 45)
            return MUT_NONE;
        return mutation_t'($urandom_range(int'(MUT_NOISE), int'(MUT_TRUNCATE)));
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    task automatic run_case(input int n_rec, input mutation_t first, input mutation_t second);
        build_frame(n_rec);
        apply_mutation(first, n_rec);
        apply_mutation(second, n_rec);
        send_frame();
    endtask

    // Header only, so the status comes from the header fields or the budget
    task automatic run_header_only(input mutation_t kind);
        build_frame(1);
        trim_frame(HEADER_LENGTH);
        apply_mutation(kind, 1);
        send_frame();
    endtask

    task automatic test_valid_frames();
        write_reg(CFG_EXPECTED_EPOCH, {$urandom(), $urandom()} | 64'd1);
        run_case(2, MUT_NONE, MUT_NONE);
    endtask

    task automatic test_header_errors();
        build_frame(1);
        trim_frame(1);
        send_frame();
        build_frame(1);
        trim_frame(HEADER_LENGTH - 1);
        send_frame();
        // last byte on the header boundary, then inside a record
        build_frame(1);
        trim_frame(HEADER_LENGTH);
        send_frame();
        build_frame(1);
        trim_frame(HEADER_LENGTH + 9);
        send_frame();
        run_header_only(MUT_MAGIC);
        run_header_only(MUT_SCHEMA);
        run_header_only(MUT_HDR_RSVD);
        run_header_only(MUT_COUNT_ZERO);
        run_case(1, MUT_DECLARED, MUT_NONE);
        run_case(1, MUT_EXTRA, MUT_NONE);
        run_case(1, MUT_EPOCH, MUT_NONE);
    endtask

    task automatic test_record_errors();
        run_case(1, MUT_FLAGS, MUT_NONE);
        run_case(1, MUT_RECSIZE, MUT_NONE);
        run_case(1, MUT_OPCODE, MUT_NONE);
        run_case(1, MUT_BINDING, MUT_NONE);
        run_case(1, MUT_ARG_ONE, MUT_NONE);
        run_case(1, MUT_REC_RSVD, MUT_NONE);
        run_case(2, MUT_OPCODE, MUT_BINDING);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_MAX_BYTES, 64'd0);
        run_header_only(MUT_NONE);
        build_frame(1);
        trim_frame(1);
        send_frame();
        // budget cuts off tentative commands part way through
        write_reg(CFG_MAX_BYTES, 64'(HEADER_LENGTH + RECORD_LENGTH));
        run_case(2, MUT_NONE, MUT_NONE);
        write_reg(CFG_MAX_BYTES, 64'hFFFF_FFFF);
        write_reg(CFG_MAX_COMMANDS, 64'd0);
        run_header_only(MUT_NONE);
        write_reg(CFG_MAX_COMMANDS, 64'd1);
        run_case(1, MUT_NONE, MUT_NONE);
        run_header_only(MUT_COUNT_HIGH);
        write_reg(CFG_MAX_COMMANDS, 64'hFFFF);
        write_reg(CFG_EXPECTED_EPOCH, 64'd0);
        run_case(1, MUT_NONE, MUT_NONE);
        write_reg(CFG_EXPECTED_EPOCH, 64'hFFFF_FFFF_FFFF_FFFF);
        run_case(1, MUT_NONE, MUT_NONE);
        write_reg(CFG_MAGIC_WORD, 64'd0);
        write_reg(CFG_SCHEMA_VERSION, 64'd0);
        write_reg(CFG_SET_OPCODE, 64'd0);
        run_case(1, MUT_NONE, MUT_NONE);
        write_reg(CFG_MAGIC_WORD, 64'hFFFF_FFFF);
        write_reg(CFG_SCHEMA_VERSION, 64'hFFFF);
        write_reg(CFG_SET_OPCODE, 64'hFFFF);
        run_case(1, MUT_NONE, MUT_NONE);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        run_case(3, MUT_NONE, MUT_NONE);
        run_header_only(MUT_NONE);
        wait_idle();
        run_case(1, MUT_NONE, MUT_NONE);
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct);
        int start_bytes;
        int n_rec;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_bytes    = bytes_sent;
        while (bytes_sent - start_bytes < PHASE_BYTES)
        begin
            n_rec = ($urandom_range(7) == 0) ? $urandom_range(8, 1) : $urandom_range(3, 1);
            run_case(n_rec, pick_mutation(),
                     ($urandom_range(3) == 0) ? pick_mutation() : MUT_NONE);
        end
        wait_idle();
    endtask

    task automatic test_random();
        write_reg(CFG_MAGIC_WORD, 64'd1111709249);
        write_reg(CFG_SCHEMA_VERSION, 64'd1);
        write_reg(CFG_SET_OPCODE, 64'd1);
        write_reg(CFG_EXPECTED_EPOCH, {$urandom(), $urandom()} | 64'd1);
        random_phase(0, 0);

        write_reg(CFG_MAGIC_WORD, 64'($urandom()));
        write_reg(CFG_SCHEMA_VERSION, 64'($urandom_range(65535)));
        write_reg(CFG_SET_OPCODE, 64'($urandom_range(65535)));
        write_reg(CFG_MAX_COMMANDS, 64'($urandom_range(6, 1)));
        random_phase(54, 0);

        write_reg(CFG_MAX_COMMANDS, 64'hFFFF);
        write_reg(CFG_MAX_BYTES, 64'($urandom_range(200, 60)));
        random_phase(0, 54);

        write_reg(CFG_MAX_BYTES, 64'hFFFF_FFFF);
        write_reg(CFG_EXPECTED_EPOCH, {$urandom(), $urandom()} | 64'd1);
        random_phase(25, 25);
    endtask

    initial
    begin
        max_bytes_cfg    = 32'hFFFF_FFFF;
        max_commands_cfg = 16'hFFFF;
        epoch_cfg        = 64'd0;
        magic_cfg        = 32'd1111709249;
        schema_cfg       = 16'd1;
        opcode_cfg       = 16'd1;
        clear_stream();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_frames();
        test_header_errors();
        test_record_errors();
        test_config_extremes();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
